// ===== design/lpm_pkg.sv =====
// Shared types and constants of the longest-prefix-match route table.
package lpm_pkg;

  localparam int unsigned IN_ADDR_W = 32;
  localparam int unsigned PLEN_W    = 6;
  localparam int unsigned TERM_W    = 16;
  localparam int unsigned LIMIT_W   = 7;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic capture;
    logic write;
    logic scan_read;
    logic result_load;
  } lpm_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic room;
    logic empty;
    logic scan_last;
    logic out_free;
  } lpm_sts_t;

endpackage

// ===== design/lpm_ctrl.sv =====
// Controller state machine that sequences adds and table scans.
module lpm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lpm_pkg::lpm_sts_t sts_i,
  output lpm_pkg::lpm_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts_i.is_lookup) begin
          cmd_o.write = sts_i.room;
          state_d     = ST_DONE;
        end else if (sts_i.empty) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_read = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/lpm_datapath.sv =====
// Datapath with the entry memory, entry count, limit register and best-match tracking.
module lpm_datapath #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpm_pkg::lpm_cmd_t             cmd_i,
  output lpm_pkg::lpm_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [lpm_pkg::LIMIT_W-1:0]   cfg_entry_limit_i,
  input  logic                          req_type_i,
  input  logic [lpm_pkg::IN_ADDR_W-1:0] address_i,
  input  logic [lpm_pkg::PLEN_W-1:0]    prefix_length_i,
  input  logic [lpm_pkg::TERM_W-1:0]    terminal_id_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          add_ok_o,
  output logic                          found_o,
  output logic [lpm_pkg::TERM_W-1:0]    match_terminal_o
);

  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned LEN_W  = $clog2(ADDR_BITS + 1);
  localparam int unsigned CMP_W  = (CNT_W > lpm_pkg::LIMIT_W) ? CNT_W : lpm_pkg::LIMIT_W;
  localparam int unsigned LCMP_W = (LEN_W > lpm_pkg::PLEN_W) ? LEN_W : lpm_pkg::PLEN_W;

  logic [ADDR_BITS-1:0]      prefix_mem [TABLE_DEPTH];
  logic [LEN_W-1:0]          len_mem    [TABLE_DEPTH];
  logic [lpm_pkg::TERM_W-1:0] term_mem  [TABLE_DEPTH];

  logic [CNT_W-1:0]            count_q;
  logic [lpm_pkg::LIMIT_W-1:0] limit_q;
  logic [IDX_W-1:0]            idx_q;
  logic                        rd_vld_q;
  logic                        hit_q;
  logic                        out_valid_q;
  logic                        add_ok_q;

  logic                       req_q;
  logic [ADDR_BITS-1:0]       addr_q;
  logic [LEN_W-1:0]           len_q;
  logic [lpm_pkg::TERM_W-1:0] term_q;

  logic [ADDR_BITS-1:0]       rd_prefix_q;
  logic [LEN_W-1:0]           rd_len_q;
  logic [lpm_pkg::TERM_W-1:0] rd_term_q;
  logic [LEN_W-1:0]           best_len_q;
  logic [lpm_pkg::TERM_W-1:0] best_term_q;

  logic                       out_add_ok_q;
  logic                       out_found_q;
  logic [lpm_pkg::TERM_W-1:0] out_term_q;

  logic [ADDR_BITS-1:0] addr_in;
  logic [LCMP_W-1:0]    len_ext;
  logic [LEN_W-1:0]     len_sat;
  logic [CMP_W-1:0]     limit_ext;
  logic [CMP_W-1:0]     count_ext;
  logic [CMP_W-1:0]     eff_limit;
  logic [ADDR_BITS-1:0] ones;
  logic [ADDR_BITS-1:0] mask;
  logic                 match;
  logic                 take;

  if (ADDR_BITS == lpm_pkg::IN_ADDR_W) begin : g_addr_eq
    assign addr_in = address_i;
  end else if (ADDR_BITS > lpm_pkg::IN_ADDR_W) begin : g_addr_wide
    assign addr_in = {{(ADDR_BITS - lpm_pkg::IN_ADDR_W){1'b0}}, address_i};
  end else begin : g_addr_narrow
    assign addr_in = address_i[ADDR_BITS-1:0];
  end

  assign len_ext = LCMP_W'(prefix_length_i);
  assign len_sat = (len_ext > LCMP_W'(ADDR_BITS)) ? LEN_W'(ADDR_BITS) : LEN_W'(len_ext);

  assign limit_ext = CMP_W'(limit_q);
  assign count_ext = CMP_W'(count_q);
  assign eff_limit = ((limit_q == '0) || (limit_ext > CMP_W'(TABLE_DEPTH)))
                     ? CMP_W'(TABLE_DEPTH) : limit_ext;

  assign ones  = '1;
  assign mask  = ~(ones >> rd_len_q);
  assign match = (((rd_prefix_q ^ addr_q) & mask) == '0);
  assign take  = rd_vld_q && match && (!hit_q || (rd_len_q >= best_len_q));

  assign sts_o.is_lookup = (req_q == lpm_pkg::REQ_LOOKUP);
  assign sts_o.room      = (count_ext < eff_limit);
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.scan_last = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      limit_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      add_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_entry_limit_i;
      end
      if (cmd_i.write) begin
        count_q <= count_q + CNT_W'(1);
      end
      rd_vld_q <= cmd_i.scan_read;
      if (cmd_i.capture) begin
        idx_q    <= '0;
        hit_q    <= 1'b0;
        add_ok_q <= 1'b0;
      end else begin
        if (cmd_i.scan_read) begin
          idx_q <= idx_q + IDX_W'(1);
        end
        if (take) begin
          hit_q <= 1'b1;
        end
        if (cmd_i.write) begin
          add_ok_q <= 1'b1;
        end
      end
      if (cmd_i.result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q       <= req_type_i;
      addr_q      <= addr_in;
      len_q       <= len_sat;
      term_q      <= terminal_id_i;
      best_len_q  <= '0;
      best_term_q <= '0;
    end else if (take) begin
      best_len_q  <= rd_len_q;
      best_term_q <= rd_term_q;
    end
    if (cmd_i.result_load) begin
      out_add_ok_q <= add_ok_q;
      out_found_q  <= sts_o.is_lookup && hit_q;
      out_term_q   <= (sts_o.is_lookup && hit_q) ? best_term_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      prefix_mem[count_q[IDX_W-1:0]] <= addr_q;
      len_mem[count_q[IDX_W-1:0]]    <= len_q;
      term_mem[count_q[IDX_W-1:0]]   <= term_q;
    end
    if (cmd_i.scan_read) begin
      rd_prefix_q <= prefix_mem[idx_q];
      rd_len_q    <= len_mem[idx_q];
      rd_term_q   <= term_mem[idx_q];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign add_ok_o         = out_add_ok_q;
  assign found_o          = out_found_q;
  assign match_terminal_o = out_term_q;

endmodule

// ===== design/longest_prefix_match_table_top.sv =====
// Top level of the longest-prefix-match route table.
//
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    req_type_i, address_i, prefix_length_i,
//                                                terminal_id_i
// out      output     out_valid_o / out_ready_i  add_ok_o, found_o, match_terminal_o
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_entry_limit_i
//
// An add transaction passes through the execute and done states before its result is loaded.
// A lookup transaction over N stored entries reads the entry memory one entry per cycle
// in the scan state, then passes through the drain and done states; on an empty table
// it goes from the execute state straight to done.
// A new transaction is accepted the cycle after the previous result is loaded.
// Reset clears the entry count and limit; the entry memory needs no clearing.
// A stalled output holds the result and delays only the loading of the next one.
module longest_prefix_match_table_top #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [lpm_pkg::IN_ADDR_W-1:0] address_i,
  input  logic [lpm_pkg::PLEN_W-1:0]    prefix_length_i,
  input  logic [lpm_pkg::TERM_W-1:0]    terminal_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          add_ok_o,
  output logic                          found_o,
  output logic [lpm_pkg::TERM_W-1:0]    match_terminal_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpm_pkg::LIMIT_W-1:0]   cfg_entry_limit_i
);

  lpm_pkg::lpm_cmd_t cmd;
  lpm_pkg::lpm_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_valid_i),
    .cfg_entry_limit_i (cfg_entry_limit_i),
    .req_type_i        (req_type_i),
    .address_i         (address_i),
    .prefix_length_i   (prefix_length_i),
    .terminal_id_i     (terminal_id_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .add_ok_o          (add_ok_o),
    .found_o           (found_o),
    .match_terminal_o  (match_terminal_o)
  );

endmodule

// ===== design/lpm_checker.sv =====
// Port-level assertion checker for the route table, bound to the top level.
module lpm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          add_ok_o,
  input logic                          found_o,
  input logic [lpm_pkg::TERM_W-1:0]    match_terminal_o
);

  // A held result keeps its value until the transaction completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(add_ok_o) && $stable(found_o)
      && $stable(match_terminal_o))
    else $error("output result changed while stalled");

  // Only one request is in flight, so acceptance is never taken twice in a row.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a transaction was in flight");

  // A result is either an add result or a lookup result, never both.
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(add_ok_o && found_o))
    else $error("add_ok and found both set");

  // A miss or an add reports a zero terminal.
  a_zero_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_terminal_o == '0)
    else $error("nonzero terminal without a match");

endmodule

bind longest_prefix_match_table_top lpm_checker u_lpm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .add_ok_o         (add_ok_o),
  .found_o          (found_o),
  .match_terminal_o (match_terminal_o)
);

// ===== test/longest_prefix_match_table_top_tb.sv =====
// Self-checking testbench for the longest-prefix-match route table top level.
`timescale 1ns / 1ps

module longest_prefix_match_table_top_tb;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned IDLE_MAX  = 2000;
  localparam int unsigned PHASES    = 5;
  localparam int unsigned PHASE_LEN = 106;

  typedef struct packed {
    logic                       add_ok;
    logic                       found;
    logic [lpm_pkg::TERM_W-1:0] term;
  } route_result_t;

  typedef struct {
    bit                            cfg_first;
    logic [lpm_pkg::LIMIT_W-1:0]   cfg_value;
    logic                          req;
    logic [lpm_pkg::IN_ADDR_W-1:0] addr;
    logic [lpm_pkg::PLEN_W-1:0]    plen;
    logic [lpm_pkg::TERM_W-1:0]    term;
    bit                            typed;
    route_result_t                 want;
  } route_row_t;

  localparam route_result_t NO_HIT  = {1'b0, 1'b0, 16'h0000};
  localparam route_result_t REFUSED = {1'b0, 1'b0, 16'h0000};
  localparam route_result_t STORED  = {1'b1, 1'b0, 16'h0000};

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          req_type = lpm_pkg::REQ_ADD;
  logic [lpm_pkg::IN_ADDR_W-1:0] address = '0;
  logic [lpm_pkg::PLEN_W-1:0]    prefix_length = '0;
  logic [lpm_pkg::TERM_W-1:0]    terminal_id = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          add_ok;
  logic                          found;
  logic [lpm_pkg::TERM_W-1:0]    match_terminal;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lpm_pkg::LIMIT_W-1:0]   cfg_entry_limit = '0;

  logic [lpm_pkg::IN_ADDR_W-1:0] route_prefix [DEPTH];
  logic [lpm_pkg::PLEN_W-1:0]    route_len [DEPTH];
  logic [lpm_pkg::TERM_W-1:0]    route_term [DEPTH];
  int unsigned                   route_count = 0;
  logic [lpm_pkg::LIMIT_W-1:0]   route_limit = '0;

  route_result_t                 expected_q[$];
  route_row_t                    directed_rows[$];
  bit                            next_cfg = 1'b0;
  logic [lpm_pkg::LIMIT_W-1:0]   next_cfg_value = '0;
  bit                            steady = 1'b0;
  int unsigned                   errors = 0;
  int unsigned                   idle_cycles = 0;
  int unsigned                   n_adds = 0;
  int unsigned                   n_stored = 0;
  int unsigned                   n_lookups = 0;
  int unsigned                   n_hits = 0;
  int unsigned                   n_limits = 0;
  logic [lpm_pkg::LIMIT_W-1:0]   phase_limit [PHASES] = '{7'd20, 7'd0, 7'd5, 7'd64, 7'd100};

  longest_prefix_match_table_top u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .req_type_i        (req_type),
    .address_i         (address),
    .prefix_length_i   (prefix_length),
    .terminal_id_i     (terminal_id),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .add_ok_o          (add_ok),
    .found_o           (found),
    .match_terminal_o  (match_terminal),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_entry_limit_i (cfg_entry_limit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [lpm_pkg::IN_ADDR_W-1:0] prefix_mask(
      input logic [lpm_pkg::PLEN_W-1:0] len);
    if (len == 0) begin
      return '0;
    end
    return 32'hFFFF_FFFF << (ADDR_W - len);
  endfunction

  function automatic route_result_t route_step(input logic req,
                                               input logic [lpm_pkg::IN_ADDR_W-1:0] addr,
                                               input logic [lpm_pkg::PLEN_W-1:0] plen,
                                               input logic [lpm_pkg::TERM_W-1:0] term);
    route_result_t              res;
    int unsigned                cap;
    logic [lpm_pkg::PLEN_W-1:0] best_len;
    res = NO_HIT;
    best_len = '0;
    if (req == lpm_pkg::REQ_ADD) begin
      n_adds++;
      cap = (route_limit == 0 || route_limit > DEPTH) ? DEPTH : route_limit;
      if (route_count < cap) begin
        route_prefix[route_count] = addr;
        route_len[route_count]    = (plen > ADDR_W) ? lpm_pkg::PLEN_W'(ADDR_W) : plen;
        route_term[route_count]   = term;
        route_count++;
        res.add_ok = 1'b1;
        n_stored++;
      end
    end else begin
      n_lookups++;
      for (int unsigned i = 0; i < route_count; i++) begin
        if (((route_prefix[i] ^ addr) & prefix_mask(route_len[i])) == 0 &&
            (!res.found || route_len[i] >= best_len)) begin
          res.found = 1'b1;
          res.term  = route_term[i];
          best_len  = route_len[i];
        end
      end
      if (res.found) begin
        n_hits++;
      end
    end
    return res;
  endfunction

  task automatic plan(input logic req, input logic [lpm_pkg::IN_ADDR_W-1:0] addr,
                      input logic [lpm_pkg::PLEN_W-1:0] plen,
                      input logic [lpm_pkg::TERM_W-1:0] term,
                      input bit typed, input route_result_t want);
    route_row_t r;
    r.cfg_first = next_cfg;
    r.cfg_value = next_cfg_value;
    r.req       = req;
    r.addr      = addr;
    r.plen      = plen;
    r.term      = term;
    r.typed     = typed;
    r.want      = want;
    directed_rows.insert(directed_rows.size(), r);
    next_cfg = 1'b0;
  endtask

  task automatic plan_limit(input logic [lpm_pkg::LIMIT_W-1:0] value);
    next_cfg       = 1'b1;
    next_cfg_value = value;
  endtask

  task automatic send_req(input route_row_t r);
    route_result_t want;
    while (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= r.req;
    address       <= r.addr;
    prefix_length <= r.plen;
    terminal_id   <= r.term;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    want = route_step(r.req, r.addr, r.plen, r.term);
    if (r.typed) begin
      want = r.want;
    end
    expected_q.insert(expected_q.size(), want);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(input logic [lpm_pkg::LIMIT_W-1:0] value);
    cfg_valid       <= 1'b1;
    cfg_entry_limit <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    route_limit = value;
    n_limits++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random();
    route_row_t                    r;
    int unsigned                   pick;
    int unsigned                   flip;
    logic [lpm_pkg::IN_ADDR_W-1:0] m;
    r.cfg_first = 1'b0;
    r.cfg_value = '0;
    r.typed     = 1'b0;
    r.want      = NO_HIT;
    r.addr      = $urandom;
    r.plen      = lpm_pkg::PLEN_W'($urandom_range(63));
    r.term      = lpm_pkg::TERM_W'($urandom);
    if ($urandom_range(99) < 30) begin
      r.req  = lpm_pkg::REQ_ADD;
      r.plen = ($urandom_range(99) < 85) ? lpm_pkg::PLEN_W'($urandom_range(ADDR_W))
                                         : lpm_pkg::PLEN_W'($urandom_range(63, 33));
      if (route_count != 0 && $urandom_range(1) == 1) begin
        pick   = $urandom_range(route_count - 1);
        m      = prefix_mask(route_len[pick]);
        r.addr = (route_prefix[pick] & m) | (r.addr & ~m);
      end
    end else begin
      r.req = lpm_pkg::REQ_LOOKUP;
      if (route_count != 0 && $urandom_range(99) < 75) begin
        pick   = $urandom_range(route_count - 1);
        m      = prefix_mask(route_len[pick]);
        r.addr = (route_prefix[pick] & m) | (r.addr & ~m);
        if (route_len[pick] != 0 && $urandom_range(9) == 0) begin
          flip = ADDR_W - 1 - $urandom_range(route_len[pick] - 1);
          r.addr[flip] = ~r.addr[flip];
        end
      end
    end
    send_req(r);
  endtask

  task automatic check_field(input string name, input logic [lpm_pkg::TERM_W-1:0] want,
                             input logic [lpm_pkg::TERM_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin : result_check
    route_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected, actual add_ok %b found %b terminal %h",
                 $time, add_ok, found, match_terminal);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("add_ok", lpm_pkg::TERM_W'(want.add_ok), lpm_pkg::TERM_W'(add_ok));
        check_field("found", lpm_pkg::TERM_W'(want.found), lpm_pkg::TERM_W'(found));
        check_field("match_terminal", want.term, match_terminal);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_MAX) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_MAX);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    plan(lpm_pkg::REQ_LOOKUP, 32'h0000_0000, 6'd63, 16'hFFFF, 1'b1, NO_HIT);
    plan(lpm_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 1'b1, NO_HIT);
    plan(lpm_pkg::REQ_ADD,    32'hFFFF_FFFF, 6'd0,  16'hFFFF, 1'b1, STORED);
    plan(lpm_pkg::REQ_LOOKUP, 32'h1234_5678, 6'd0,  16'h0000, 1'b1, {1'b0, 1'b1, 16'hFFFF});
    plan_limit(7'd2);
    plan(lpm_pkg::REQ_ADD,    32'h0000_0000, 6'd32, 16'h0000, 1'b1, STORED);
    plan(lpm_pkg::REQ_ADD,    32'h0A00_0000, 6'd8,  16'h1111, 1'b1, REFUSED);
    plan(lpm_pkg::REQ_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1'b1, {1'b0, 1'b1, 16'h0000});
    plan(lpm_pkg::REQ_LOOKUP, 32'h0000_0001, 6'd0,  16'h0000, 1'b1, {1'b0, 1'b1, 16'hFFFF});
    plan_limit(7'd1);
    plan(lpm_pkg::REQ_ADD,    32'h0A00_0000, 6'd8,  16'h2222, 1'b1, REFUSED);
    plan(lpm_pkg::REQ_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1'b1, {1'b0, 1'b1, 16'h0000});
    plan_limit(7'd127);
    plan(lpm_pkg::REQ_ADD,    32'h8000_0000, 6'd1,  16'h0001, 1'b1, STORED);
    plan(lpm_pkg::REQ_ADD,    32'hC0A8_0000, 6'd63, 16'h0002, 1'b1, STORED);
    plan(lpm_pkg::REQ_ADD,    32'hC0A8_0000, 6'd16, 16'h0003, 1'b1, STORED);
    plan(lpm_pkg::REQ_ADD,    32'hC0A8_FFFF, 6'd16, 16'h0004, 1'b1, STORED);
    plan(lpm_pkg::REQ_ADD,    32'hC0A8_0001, 6'd33, 16'h0005, 1'b1, STORED);
    plan(lpm_pkg::REQ_LOOKUP, 32'hC0A8_0000, 6'd0,  16'h0000, 1'b0, NO_HIT);
    plan(lpm_pkg::REQ_LOOKUP, 32'hC0A8_1234, 6'd0,  16'h0000, 1'b0, NO_HIT);
    plan(lpm_pkg::REQ_LOOKUP, 32'hC0A8_0001, 6'd0,  16'h0000, 1'b0, NO_HIT);
    plan(lpm_pkg::REQ_LOOKUP, 32'h8000_0000, 6'd0,  16'h0000, 1'b0, NO_HIT);
    plan(lpm_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 6'd0,  16'h0000, 1'b0, NO_HIT);
    plan(lpm_pkg::REQ_ADD,    32'h0000_0000, 6'd0,  16'h00AA, 1'b1, STORED);
    plan(lpm_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 6'd0,  16'h0000, 1'b0, NO_HIT);
    plan(lpm_pkg::REQ_LOOKUP, 32'hC0A8_0002, 6'd0,  16'h0000, 1'b0, NO_HIT);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_first) begin
        drain();
        write_limit(directed_rows[i].cfg_value);
      end
      send_req(directed_rows[i]);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_limit(phase_limit[ph]);
      steady = (ph == 1);
      repeat (PHASE_LEN) send_random();
    end
    steady = 1'b0;
    drain();
    repeat (80) @(negedge clk);

    $display("Covered %0d adds (%0d stored) and %0d lookups (%0d hits) over %0d limit settings.",
             n_adds, n_stored, n_lookups, n_hits, n_limits);
    $display("Final table size %0d of %0d entries.", route_count, DEPTH);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
